### hw/rtl/bkrt_pkg.sv
// Shared types and constants for the button key repeat timer.
`timescale 1ns / 1ps
`default_nettype none

package bkrt_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int CLR_W   = 16;
    localparam int MS_W    = 16;
    localparam int TS_W    = 32;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_BUTTON = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    localparam logic [CFG_A_W-1:0] REG_DELAY      = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_PERIOD     = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_REPEATABLE = 2'd2;

    localparam logic [MS_W-1:0]    DELAY_RST      = 16'd500;
    localparam logic [MS_W-1:0]    PERIOD_RST     = 16'd30;
    localparam logic [CFG_D_W-1:0] REPEATABLE_RST = 16'h003C;

endpackage

`default_nettype wire

### hw/rtl/button_key_repeat_timer_top.sv
// Top level of the button key auto-repeat (typematic) timer.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one command per transfer on the input channel: a button
// press or release, a clear of held-mask bits, or a one-millisecond tick.
// A press or release gives one timestamped down or up event. While any
// repeatable button is held, the repeat timer counts ticks; after the delay,
// and then every period, a tick gives one repeat down event for each held
// repeatable button in ascending button order, the last one flagged with
// o_last_of_burst. Button indices at or above BUTTON_COUNT are ignored.
// Flow: an accepted item is held in an input register and handled, once
// the result register is free, by combinational logic that loads the result
// register, so a new item can be taken every cycle while the result register
// is not held. A repeat burst of N buttons holds the result register for N
// output transfers, one per cycle while the receiver is ready, during which
// one further item can wait in the input register. Configuration registers
// are to be written through the plain write port only while the block is idle
// (the user's duty; the block does not enforce it); a write to index 3 is ignored.

module button_key_repeat_timer_top
    import bkrt_pkg::*;
#(
    parameter int BUTTON_COUNT = 11
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port.
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CFG_A_W-1:0] i_cfg_addr,
    input  wire logic [CFG_D_W-1:0] i_cfg_wdata,
    // Command channel.
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [IDX_W-1:0]   i_button_index,
    input  wire logic               i_pressed,
    input  wire logic [CLR_W-1:0]   i_clear_bits,
    // Event channel.
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [IDX_W-1:0]        o_event_button,
    output logic                    o_is_down,
    output logic                    o_is_repeat,
    output logic [TS_W-1:0]         o_timestamp_ms,
    output logic                    o_last_of_burst
);

    localparam int BC = BUTTON_COUNT;

    // Configuration registers.
    logic [MS_W-1:0]    r_delay;
    logic [MS_W-1:0]    r_period;
    logic [CFG_D_W-1:0] r_repeatable;

    // Input register.
    logic               r_in_valid;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic               r_prs;
    logic [CLR_W-1:0]   r_clr;

    // Timer state.
    logic [BC-1:0]      r_held,  n_held;
    logic               r_armed, n_armed;
    logic [MS_W-1:0]    r_count, n_count;
    logic [TS_W-1:0]    r_clock, n_clock;

    // Result register. The mask holds the buttons still to be reported;
    // a single press or release event is a mask with one bit set.
    logic               r_out_valid;
    logic [BC-1:0]      r_mask;
    logic               r_down;
    logic               r_rep;
    logic [TS_W-1:0]    r_ts;

    logic               n_emit;
    logic [BC-1:0]      n_mask;
    logic               n_down;
    logic               n_rep;

    logic [BC-1:0]      s_rep_mask;
    logic [BC-1:0]      s_wanted;
    logic [BC-1:0]      s_idx_onehot;
    logic               s_idx_ok;
    logic               s_last;
    logic               s_out_take;
    logic               s_out_free;
    logic               s_step;
    logic [IDX_W-1:0]   s_btn;

    assign s_rep_mask = r_repeatable[BC-1:0];
    assign s_idx_ok   = ({1'b0, r_idx} < (IDX_W+1)'(BC));

    always_comb begin
        for (int j = 0; j < BC; j++) begin
            s_idx_onehot[j] = (r_idx == IDX_W'(j));
        end
    end

    // Lowest pending button of the result register.
    always_comb begin
        s_btn = '0;
        for (int j = BC - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                s_btn = IDX_W'(j);
            end
        end
    end

    assign s_last     = ((r_mask & (r_mask - BC'(1))) == '0);
    assign s_out_take = r_out_valid && i_ready;
    assign s_out_free = !r_out_valid || (s_out_take && s_last);
    assign s_step     = r_in_valid && s_out_free;
    assign o_ready    = !r_in_valid || s_step;

    // Command handling: next timer state and the result to load.
    always_comb begin
        n_held   = r_held;
        n_armed  = r_armed;
        n_count  = r_count;
        n_clock  = r_clock;
        n_emit   = 1'b0;
        n_mask   = '0;
        n_down   = 1'b0;
        n_rep    = 1'b0;
        s_wanted = '0;
        case (r_cmd)
            CMD_BUTTON: begin
                if (s_idx_ok) begin
                    n_held   = r_prs ? (r_held | s_idx_onehot) : (r_held & ~s_idx_onehot);
                    s_wanted = n_held & s_rep_mask;
                    n_emit   = 1'b1;
                    n_mask   = s_idx_onehot;
                    n_down   = r_prs;
                    if ((s_wanted != '0) && !r_armed) begin
                        n_armed = 1'b1;
                        n_count = (r_delay != '0) ? r_delay : MS_W'(1);
                    end else if ((s_wanted == '0) && r_armed) begin
                        n_armed = 1'b0;
                        n_count = '0;
                    end
                end
            end
            CMD_CLEAR: begin
                n_held   = r_held & ~r_clr[BC-1:0];
                s_wanted = n_held & s_rep_mask;
                if (r_armed && (s_wanted == '0)) begin
                    n_armed = 1'b0;
                    n_count = '0;
                end
            end
            CMD_TICK: begin
                n_clock  = r_clock + TS_W'(1);
                s_wanted = r_held & s_rep_mask;
                if (r_armed) begin
                    if (r_count > MS_W'(1)) begin
                        n_count = r_count - MS_W'(1);
                    end else if (s_wanted == '0) begin
                        // Nothing repeatable is held any more.
                        n_armed = 1'b0;
                        n_count = '0;
                    end else begin
                        n_emit = 1'b1;
                        n_mask = s_wanted;
                        n_down = 1'b1;
                        n_rep  = 1'b1;
                        if (r_period == '0) begin
                            n_armed = 1'b0;
                            n_count = '0;
                        end else begin
                            n_count = r_period;
                        end
                    end
                end
            end
            default: begin
                // Unused command code: no effect.
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay      <= DELAY_RST;
            r_period     <= PERIOD_RST;
            r_repeatable <= REPEATABLE_RST;
            r_in_valid   <= 1'b0;
            r_held       <= '0;
            r_armed      <= 1'b0;
            r_count      <= '0;
            r_clock      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_DELAY:      r_delay      <= i_cfg_wdata;
                    REG_PERIOD:     r_period     <= i_cfg_wdata;
                    REG_REPEATABLE: r_repeatable <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (s_step) begin
                r_held  <= n_held;
                r_armed <= n_armed;
                r_count <= n_count;
                r_clock <= n_clock;
            end
            if (s_step && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (s_out_take && s_last) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= t_cmd'(i_cmd);
            r_idx <= i_button_index;
            r_prs <= i_pressed;
            r_clr <= i_clear_bits;
        end
        if (s_step && n_emit) begin
            r_mask <= n_mask;
            r_down <= n_down;
            r_rep  <= n_rep;
            r_ts   <= n_clock;
        end else if (s_out_take) begin
            // Drop the button just transferred.
            r_mask <= r_mask & (r_mask - BC'(1));
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_button  = s_btn;
    assign o_is_down       = r_down;
    assign o_is_repeat     = r_rep;
    assign o_timestamp_ms  = r_ts;
    assign o_last_of_burst = s_last;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the button key auto-repeat timer.
`timescale 1ns / 1ps

module tb;
    import bkrt_pkg::*;

    // The block is built with its default button count; the predictor uses the same value.
    localparam int NBTN = 11;
    localparam logic [15:0] BTN_MASK = 16'((1 << NBTN) - 1);

    // The fourth command code has no meaning; the block must drop such items.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Register index 3 has no register behind it; writes to it are dropped.
    localparam logic [CFG_A_W-1:0] REG_UNUSED = 2'd3;

    // Cycles to let pass once the last expected event has come. This covers the
    // input register and the result register, so that a tick or a clear still
    // in flight has finished before a register is written.
    localparam int SETTLE_CYCLES = 6;
    // Extra cycles at the very end to catch a stray event.
    localparam int END_CYCLES = 12;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES = 300;
    // The run is declared hung after this many cycles without any transfer.
    localparam int IDLE_LIMIT = 5000;

    // One event as the block should emit it.
    typedef struct packed {
        logic [IDX_W-1:0] button;
        logic             down;
        logic             repeated;
        logic [TS_W-1:0]  stamp;
        logic             last;
    } t_event;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [CFG_A_W-1:0] i_cfg_addr;
    logic [CFG_D_W-1:0] i_cfg_wdata;
    logic               i_valid;
    logic               o_ready;
    logic [CMD_W-1:0]   i_cmd;
    logic [IDX_W-1:0]   i_button_index;
    logic               i_pressed;
    logic [CLR_W-1:0]   i_clear_bits;
    logic               o_valid;
    logic               i_ready;
    logic [IDX_W-1:0]   o_event_button;
    logic               o_is_down;
    logic               o_is_repeat;
    logic [TS_W-1:0]    o_timestamp_ms;
    logic               o_last_of_burst;

    button_key_repeat_timer_top #(
        .BUTTON_COUNT(NBTN)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_button_index (i_button_index),
        .i_pressed      (i_pressed),
        .i_clear_bits   (i_clear_bits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_button (o_event_button),
        .o_is_down      (o_is_down),
        .o_is_repeat    (o_is_repeat),
        .o_timestamp_ms (o_timestamp_ms),
        .o_last_of_burst(o_last_of_burst)
    );

    // Events predicted for accepted commands, oldest first.
    t_event pending_events[$];
    int     errors;

    // Predictor copy of the registers and the timer state.
    logic [15:0] cfg_delay;
    logic [15:0] cfg_period;
    logic [15:0] cfg_repeatable;
    logic [15:0] mdl_held;
    logic        mdl_armed;
    logic [15:0] mdl_countdown;
    logic [31:0] mdl_clock;

    // Sender burst bookkeeping and the request for a long receiver hold-off.
    int burst_left;
    bit stall_request;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_model();
        cfg_delay      = DELAY_RST;
        cfg_period     = PERIOD_RST;
        cfg_repeatable = REPEATABLE_RST;
        mdl_held       = '0;
        mdl_armed      = 1'b0;
        mdl_countdown  = '0;
        mdl_clock      = '0;
    endtask

    // Held buttons that take part in auto-repeat; bits past the button count never count.
    function automatic logic [15:0] live_repeaters();
        return mdl_held & cfg_repeatable & BTN_MASK;
    endfunction

    task automatic stop_timer();
        mdl_armed     = 1'b0;
        mdl_countdown = '0;
    endtask

    // Works out the events that one accepted command causes and queues them.
    task automatic predict_events(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                  input logic prs, input logic [CLR_W-1:0] clr);
        t_event      ev;
        logic [15:0] send;
        case (cmd)
            CMD_BUTTON: begin
                // Buttons past the count are dropped without an event.
                if (int'(idx) < NBTN) begin
                    mdl_held[idx] = prs;
                    ev = '{button: idx, down: prs, repeated: 1'b0, stamp: mdl_clock,
                           last: 1'b1};
                    pending_events.push_back(ev);
                    // Arming happens once per hold; a zero delay behaves as one tick.
                    if (live_repeaters() != 0 && !mdl_armed) begin
                        mdl_armed     = 1'b1;
                        mdl_countdown = (cfg_delay == 0) ? 16'd1 : cfg_delay;
                    end else if (live_repeaters() == 0 && mdl_armed) begin
                        stop_timer();
                    end
                end
            end
            CMD_CLEAR: begin
                mdl_held = mdl_held & ~clr;
                if (mdl_armed && live_repeaters() == 0) stop_timer();
            end
            CMD_TICK: begin
                // The clock advances first, so burst events carry the new value.
                mdl_clock = mdl_clock + 32'd1;
                if (mdl_armed) begin
                    if (mdl_countdown > 1) begin
                        mdl_countdown = mdl_countdown - 16'd1;
                    end else begin
                        send = live_repeaters();
                        if (send == 0) begin
                            // Nothing repeatable is held any more: an empty burst disarms.
                            stop_timer();
                        end else begin
                            for (int b = 0; b < NBTN; b++) begin
                                if (send[b]) begin
                                    ev = '{button: IDX_W'(b), down: 1'b1, repeated: 1'b1,
                                           stamp: mdl_clock,
                                           last: ((send >> b >> 1) == 0)};
                                    pending_events.push_back(ev);
                                end
                            end
                            if (cfg_period == 0) stop_timer();
                            else mdl_countdown = cfg_period;
                        end
                    end
                end
            end
            default: begin
                // The unused command code has no effect.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Command sender
    // ------------------------------------------------------------------

    // Offers one command and waits for its transfer. The sender works in bursts:
    // once a burst is used up, valid drops for a random gap before the next one.
    // Within a burst valid stays high from one command to the next.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic prs, input logic [CLR_W-1:0] clr);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_button_index <= idx;
        i_pressed      <= prs;
        i_clear_bits   <= clr;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_events(cmd, idx, prs, clr);
    endtask

    // Unused fields get random content so that the block cannot rely on them.
    task automatic send_button(input int idx, input logic prs);
        send_item(CMD_BUTTON, IDX_W'(idx), prs, CLR_W'($urandom));
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, IDX_W'($urandom), 1'($urandom), CLR_W'($urandom));
    endtask

    task automatic send_clear(input logic [CLR_W-1:0] bits);
        send_item(CMD_CLEAR, IDX_W'($urandom), 1'($urandom), bits);
    endtask

    // Stops offering commands and waits until the block has gone idle.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the write enable drops again after each write.
    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (addr)
            REG_DELAY:      cfg_delay      = data;
            REG_PERIOD:     cfg_period     = data;
            REG_REPEATABLE: cfg_repeatable = data;
            default: begin
            end
        endcase
    endtask

    task automatic configure(input logic [15:0] delay, input logic [15:0] period,
                             input logic [15:0] repeatable);
        settle();
        write_reg(REG_DELAY, delay);
        write_reg(REG_PERIOD, period);
        write_reg(REG_REPEATABLE, repeatable);
    endtask

    // ------------------------------------------------------------------
    // Event receiver and checker
    // ------------------------------------------------------------------

    // The receiver runs through stretches of its own: always ready, a coin toss,
    // a sparse pattern and a mostly-ready pattern. On request it holds off for a
    // long stretch so that the block fills up and stalls the command channel.
    initial begin : event_sink
        int mode;
        int stretch;
        mode    = 0;
        stretch = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(8, 64);
                end
                stretch--;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (stretch % 5 != 0);
                endcase
            end
        end
    end

    // Every event transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: button %0d down %0b repeat %0b at %0d ms",
                       o_event_button, o_is_down, o_is_repeat, o_timestamp_ms);
                errors++;
            end else begin
                want = pending_events.pop_front();
                if (o_event_button !== want.button) begin
                    $error("event_button: expected %0d, got %0d", want.button, o_event_button);
                    errors++;
                end
                if (o_is_down !== want.down) begin
                    $error("is_down: expected %0b, got %0b", want.down, o_is_down);
                    errors++;
                end
                if (o_is_repeat !== want.repeated) begin
                    $error("is_repeat: expected %0b, got %0b", want.repeated, o_is_repeat);
                    errors++;
                end
                if (o_timestamp_ms !== want.stamp) begin
                    $error("timestamp_ms: expected %0d, got %0d", want.stamp, o_timestamp_ms);
                    errors++;
                end
                if (o_last_of_burst !== want.last) begin
                    $error("last_of_burst: expected %0b, got %0b", want.last, o_last_of_burst);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long is a hang.
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With the reset period and repeat mask, a held arrow button repeats every
    // 30 ticks; a non-repeatable button never repeats. Only the delay is cut
    // short so that the first burst comes after two ticks.
    task automatic test_reset_timing();
        settle();
        write_reg(REG_DELAY, 16'd2);
        send_button(0, 1'b1);
        send_button(2, 1'b1);
        repeat (32) send_tick();
        send_button(2, 1'b0);
        send_button(0, 1'b0);
    endtask

    // Short directed sequence over the field extremes and the special cases.
    task automatic test_directed();
        // Zero delay acts as one tick, a zero period gives a single burst, and
        // bits above the button count in the repeat mask do nothing.
        configure(16'd0, 16'd0, 16'hFFFF);
        send_button(0, 1'b1);
        send_button(NBTN - 1, 1'b1);
        send_tick();
        send_tick();
        // The stop after the single burst disarmed the timer, so this release re-arms it.
        send_button(NBTN - 1, 1'b0);
        send_tick();
        send_button(0, 1'b0);
        // Indices past the button count and the unused command code are dropped.
        send_button(NBTN, 1'b1);
        send_item(CMD_BUTTON, 4'hF, 1'b1, 16'h0000);
        send_item(CMD_UNUSED, 4'h3, 1'b1, 16'hFFFF);
        // A clear that leaves nothing repeatable held disarms the timer.
        send_button(3, 1'b1);
        send_clear(16'hFFFF);
        send_tick();
        send_button(4, 1'b1);

        // Empty burst: the repeat mask is emptied while armed, so the countdown
        // runs out with nothing to send and the timer disarms.
        configure(16'd0, 16'd0, 16'h0000);
        send_tick();
        send_tick();
        send_button(4, 1'b0);

        // Largest delay and period: arming only, no burst within a few ticks.
        configure(16'hFFFF, 16'hFFFF, BTN_MASK);
        send_button(1, 1'b1);
        send_tick();
        send_tick();
        send_button(1, 1'b0);

        // Only unused buttons are repeatable, so nothing ever arms.
        configure(16'd1, 16'd1, 16'hF800);
        send_button(5, 1'b1);
        send_tick();
        send_button(5, 1'b0);
        settle();
        write_reg(REG_UNUSED, 16'hA5A5);
    endtask

    // All buttons held and a burst on every tick while the receiver holds off:
    // the block must stall its command channel and lose nothing.
    task automatic test_back_pressure();
        configure(16'd1, 16'd1, 16'hFFFF);
        for (int b = 0; b < NBTN; b++) send_button(b, 1'b1);
        stall_request = 1'b1;
        repeat (6) send_tick();
        for (int b = NBTN - 1; b >= 0; b--) send_button(b, 1'b0);
    endtask

    // Random commands under several register settings. Most commands are ticks
    // and presses or releases of real buttons; the rest are clears and items
    // the block should drop.
    task automatic test_random();
        int pick;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: configure(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)), 16'hFFFF);
                1: configure(16'd0, 16'd0, 16'($urandom));
                2: configure(16'($urandom_range(1, 3)), 16'd1, 16'($urandom));
                default: configure(16'd1, 16'($urandom_range(2, 5)),
                                   (16'($urandom) & BTN_MASK) | 16'h0001);
            endcase
            if (phase == 3) write_reg(REG_UNUSED, 16'($urandom));
            repeat (7) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    send_tick();
                end else if (pick < 80) begin
                    send_button($urandom_range(0, NBTN - 1), ($urandom_range(0, 9) < 6));
                end else if (pick < 88) begin
                    send_clear(16'($urandom) & 16'($urandom));
                end else if (pick < 94) begin
                    send_button($urandom_range(NBTN, 15), 1'($urandom));
                end else begin
                    send_item(CMD_UNUSED, IDX_W'($urandom), 1'($urandom), CLR_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        errors        = 0;
        burst_left    = 0;
        stall_request = 1'b0;
        reset_model();
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_addr     <= REG_DELAY;
        i_cfg_wdata    <= '0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_BUTTON;
        i_button_index <= '0;
        i_pressed      <= 1'b0;
        i_clear_bits   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_timing();
        test_directed();
        test_back_pressure();
        test_random();

        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_events.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
